>>> rtl/tps_pkg.sv
// Package for the timer prescaler and counter-top fit block.
// Holds shared types, reset constants and the prescaler divisor shift tables.
// No dependencies.
package tps_pkg;

    // Reset value of the timer input clock register in hertz.
    localparam logic [31:0] CLK_HZ_RESET = 32'd16000000;

    // Default upper bound on the counter top.
    localparam int TOP_LIMIT_DEFAULT = 65535;

    // Errors at or above this value never win.
    localparam logic [15:0] ERR_CEILING = 16'hFFFF;

    // First and last prescaler select codes that are tried.
    localparam logic [2:0] CODE_FIRST = 3'd1;
    localparam logic [2:0] CODE_LAST  = 3'd7;

    // Both divisor tables hold powers of two, so they are stored as shift amounts.
    localparam logic [3:0] SHIFT_TAB_A [8] = '{4'd0, 4'd0, 4'd3, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0};
    localparam logic [3:0] SHIFT_TAB_B [8] = '{4'd0, 4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10};

    // One queued transaction between the front and the back.
    typedef struct packed {
        logic [31:0] target;
        logic        table_sel;
        logic        zero_target;
    } tps_item_t;

    // Start request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  steps;
    } tps_div_req_t;

    // Status returned by the shared divider.
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } tps_div_rsp_t;

    // Shift amount of the divisor for a table and a select code.
    function automatic logic [3:0] tps_shift(input logic table_sel, input logic [2:0] code);
        logic [3:0] amount;
        if (table_sel) begin
            amount = SHIFT_TAB_B[code];
        end else begin
            amount = SHIFT_TAB_A[code];
        end
        return amount;
    endfunction

endpackage

>>> rtl/timer_prescaler_top_fit.sv
// Top level of the timer prescaler and counter-top fit block.
// Depends on tps_pkg, tps_front, tps_back (which holds tps_div).
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_target_frequency[31:0], s_table_select
// m_        out        m_valid/m_ready    m_prescaler_index[2:0], m_top_value[15:0]
// cfg_      in         cfg_we             cfg_wdata[31:0] (timer clock in hertz)
//
// A zero target goes straight to the result; otherwise each of the seven codes is
// either skipped or tried with up to two divisions (16 and 32 divider steps), and
// the back part finishes one transaction before it takes the next. The single
// shared one-bit-per-cycle divider runs both divisions.
// Requests queue two deep while the back part works, and a finished result waits
// in the output register without blocking the queue.
// Reset is synchronous and active low; the clock register resets to 16 MHz.
module timer_prescaler_top_fit
    import tps_pkg::*;
#(
    parameter int TOP_LIMIT = TOP_LIMIT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_target_frequency,
    input  logic        s_table_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_prescaler_index,
    output logic [15:0] m_top_value
);

    logic [31:0] clk_hz_reg;
    logic        q_valid;
    logic        q_pop;
    tps_item_t   q_item;

    // Timer clock configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLK_HZ_RESET;
        end else if (cfg_we) begin
            clk_hz_reg <= cfg_wdata;
        end
    end

    tps_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_target_frequency (s_target_frequency),
        .s_table_select     (s_table_select),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop)
    );

    tps_back #(
        .TOP_LIMIT (TOP_LIMIT)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .clk_hz            (clk_hz_reg),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_prescaler_index (m_prescaler_index),
        .m_top_value       (m_top_value)
    );

endmodule

>>> rtl/tps_front.sv
// Front part: accepts request transactions, flags a zero target and queues them.
// Depends on tps_pkg. Two-entry queue toward the back part.
module tps_front
    import tps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_target_frequency,
    input  logic        s_table_select,
    output logic        q_valid,
    output tps_item_t   q_item,
    input  logic        q_pop
);

    tps_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    tps_item_t  new_item;

    // Classify the incoming transaction.
    always_comb begin
        new_item.target      = s_target_frequency;
        new_item.table_sel   = s_table_select;
        new_item.zero_target = (s_target_frequency == 32'd0);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    // The back part never pops an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("tps_front: pop from empty queue");
    // A full queue stays full when nothing is popped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) && !q_pop |=> (count_reg == 2'd2))
        else $error("tps_front: queue lost an entry");
    // The count never exceeds the depth.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("tps_front: queue overflow");

endmodule

>>> rtl/tps_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tps_pkg. Takes a starting remainder so a partial division can be run.
module tps_div
    import tps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  tps_div_req_t req,
    output tps_div_rsp_t rsp
);

    logic [31:0] rem_reg;
    logic [31:0] dq_reg;
    logic [31:0] divisor_reg;
    logic [31:0] quot_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] trial;
    logic        ge;

    // One restoring step.
    always_comb begin
        shifted = {rem_reg, dq_reg[31]};
        ge      = (shifted >= {1'b0, divisor_reg});
        trial   = shifted - {1'b0, divisor_reg};
    end

    // Control: step counter and done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= req.rem_init;
            dq_reg      <= req.dividend;
            divisor_reg <= req.divisor;
            quot_reg    <= 32'd0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? trial[31:0] : shifted[31:0];
            dq_reg   <= {dq_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    // A new division never starts while one is running.
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |-> !busy_reg)
        else $error("tps_div: start while busy");
    // Done follows the last step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (cnt_reg == 6'd1) && !req.start |=> done_reg)
        else $error("tps_div: missing done");
    // Start requests a nonzero step count.
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |-> (req.steps != 6'd0))
        else $error("tps_div: zero step count");

endmodule

>>> rtl/tps_back.sv
// Back part: walks the prescaler codes, runs the shared divider and keeps the best fit.
// Depends on tps_pkg and tps_div. Holds the result register of the output channel.
module tps_back
    import tps_pkg::*;
#(
    parameter int TOP_LIMIT = TOP_LIMIT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] clk_hz,
    input  logic        q_valid,
    input  tps_item_t   q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_prescaler_index,
    output logic [15:0] m_top_value
);

    localparam logic [15:0] TopLim = 16'(TOP_LIMIT);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CAND = 5'b00010,
        S_TOP  = 5'b00100,
        S_ACT  = 5'b01000,
        S_FIN  = 5'b10000
    } tps_state_t;

    tps_state_t   state_reg, state_next;
    logic [31:0]  target_reg;
    logic         sel_reg;
    logic [2:0]   code_reg, code_next;
    logic [31:0]  presc_reg;
    logic [15:0]  top_reg;
    logic [15:0]  best_err_reg, best_err_next;
    logic [15:0]  win_top_reg, win_top_next;
    logic [2:0]   best_code_reg, best_code_next;
    logic         out_valid_reg;
    logic [2:0]   out_index_reg;
    logic [15:0]  out_top_reg;
    logic         out_load;
    logic [31:0]  presc;
    logic         fits;
    logic [15:0]  top_q;
    logic [31:0]  actual;
    logic [31:0]  err;
    tps_div_req_t div_req;
    tps_div_rsp_t div_rsp;

    tps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Candidate classification and error of the finished candidate.
    always_comb begin
        presc  = clk_hz >> tps_shift(sel_reg, code_reg);
        fits   = (target_reg <= presc) && ({16'd0, presc[31:16]} < target_reg);
        top_q  = div_rsp.quotient[15:0];
        actual = div_rsp.quotient;
        err    = (actual >= target_reg) ? (actual - target_reg) : (target_reg - actual);
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        code_next      = code_reg;
        best_err_next  = best_err_reg;
        win_top_next   = win_top_reg;
        best_code_next = best_code_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        div_req        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop          = 1'b1;
                    code_next      = CODE_FIRST;
                    best_err_next  = ERR_CEILING;
                    win_top_next   = 16'd0;
                    best_code_next = 3'd0;
                    state_next     = q_item.zero_target ? S_FIN : S_CAND;
                end
            end
            S_CAND: begin
                if (fits) begin
                    // Top fits in 16 bits, so only the low 16 quotient bits remain.
                    div_req.start    = 1'b1;
                    div_req.rem_init = {16'd0, presc[31:16]};
                    div_req.dividend = {presc[15:0], 16'd0};
                    div_req.divisor  = target_reg;
                    div_req.steps    = 6'd16;
                    state_next       = S_TOP;
                end else if (code_reg == CODE_LAST) begin
                    state_next = S_FIN;
                end else begin
                    code_next = code_reg + 3'd1;
                end
            end
            S_TOP: begin
                if (div_rsp.done) begin
                    if (top_q > TopLim) begin
                        if (code_reg == CODE_LAST) begin
                            state_next = S_FIN;
                        end else begin
                            code_next  = code_reg + 3'd1;
                            state_next = S_CAND;
                        end
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = 32'd0;
                        div_req.dividend = presc_reg;
                        div_req.divisor  = {16'd0, top_q};
                        div_req.steps    = 6'd32;
                        state_next       = S_ACT;
                    end
                end
            end
            S_ACT: begin
                if (div_rsp.done) begin
                    if (err < {16'd0, best_err_reg}) begin
                        best_err_next  = err[15:0];
                        win_top_next   = top_reg;
                        best_code_next = code_reg;
                    end
                    if (code_reg == CODE_LAST) begin
                        state_next = S_FIN;
                    end else begin
                        code_next  = code_reg + 3'd1;
                        state_next = S_CAND;
                    end
                end
            end
            S_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        best_err_reg  <= best_err_next;
        win_top_reg   <= win_top_next;
        best_code_reg <= best_code_next;
        if (q_pop) begin
            target_reg <= q_item.target;
            sel_reg    <= q_item.table_sel;
        end
        if (state_reg == S_CAND) begin
            presc_reg <= presc;
        end
        if ((state_reg == S_TOP) && div_rsp.done) begin
            top_reg <= top_q;
        end
        if (out_load) begin
            out_index_reg <= best_code_reg;
            out_top_reg   <= (best_code_reg != 3'd0) ? (win_top_reg - 16'd1) : 16'd0;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_prescaler_index = out_index_reg;
    assign m_top_value       = out_top_reg;

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("tps_back: result overwritten");
    // A chosen code always carries an error below the ceiling.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) && (best_code_reg != 3'd0) |-> (best_err_reg < ERR_CEILING))
        else $error("tps_back: winner with error at ceiling");
    // Items are taken from the queue only between transactions.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> (state_reg == S_IDLE))
        else $error("tps_back: pop while busy");

endmodule
